// ----- hw/rtl/deq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, sizes and helpers of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    // storage geometry
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = ADDR_W + 1;

    // fixed field widths of the channels
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // request codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_POP_BACK   = 3'd1,
        ACT_PUSH_FRONT = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_PEEK_BACK  = 3'd4,
        ACT_PEEK_FRONT = 3'd5,
        ACT_CLEAR      = 3'd6
    } action_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // storage operation handed to the back end
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } mem_op_t;

    // command travelling from the front end to the back end
    typedef struct packed {
        mem_op_t                 op;
        logic [ADDR_W-1:0]       addr;
        logic [DATA_WIDTH-1:0]   data;
        logic [CNT_W-1:0]        count;
        status_t                 status;
    } cmd_t;

    // reduce a sum below twice the depth into a slot number
    function automatic logic [ADDR_W-1:0] wrap_slot(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] red;
        begin
            red = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
            return red[ADDR_W-1:0];
        end
    endfunction

endpackage

// ----- hw/rtl/deq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_if
// Request and result channels of the double-ended queue.
// ----------------------------------------------------------------------------
interface deq_req_if;
    import deq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface deq_rsp_if;
    import deq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  result_value;
    logic [COUNT_W-1:0]         element_count;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, output result_value, output element_count,
                    output status, input ready);
    modport sink   (input valid, input result_value, input element_count,
                    input status, output ready);
endinterface

// ----- hw/rtl/deq_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_front
// Takes requests, keeps the front pointer and count, and issues storage
// commands with their final count and status.
// ----------------------------------------------------------------------------
module deq_front
    import deq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    deq_req_if.sink     req,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    logic [ADDR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              xfer;

    logic [ADDR_W-1:0] back_free_slot;
    logic [ADDR_W-1:0] back_used_slot;
    logic [ADDR_W-1:0] front_dec;
    logic [ADDR_W-1:0] front_inc;
    logic              is_full;
    logic              is_empty;

    assign req.ready = cmd_ready;
    assign cmd_valid = req.valid;
    assign xfer      = req.valid && cmd_ready;

    // slot arithmetic around the ring
    assign is_full        = (count_reg == CNT_W'(DEPTH));
    assign is_empty       = (count_reg == '0);
    assign back_free_slot = wrap_slot(SUM_W'(front_reg) + SUM_W'(count_reg));
    assign back_used_slot = wrap_slot(SUM_W'(front_reg) + SUM_W'(count_reg) - SUM_W'(1));
    assign front_dec      = (front_reg == '0) ? ADDR_W'(DEPTH - 1) : (front_reg - ADDR_W'(1));
    assign front_inc      = (front_reg == ADDR_W'(DEPTH - 1)) ? '0 : (front_reg + ADDR_W'(1));

    // classify the request
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        cmd.op     = OP_NONE;
        cmd.addr   = '0;
        cmd.data   = DATA_WIDTH'($unsigned(req.value));
        cmd.status = ST_OK;
        unique case (req.action)
            ACT_PUSH_BACK, ACT_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    cmd.status = ST_FULL;
                end
                else
                begin
                    cmd.op     = OP_WRITE;
                    count_next = count_reg + CNT_W'(1);
                    if (req.action == ACT_PUSH_BACK)
                    begin
                        cmd.addr = back_free_slot;
                    end
                    else
                    begin
                        front_next = front_dec;
                        cmd.addr   = front_dec;
                    end
                end
            end
            ACT_POP_BACK, ACT_POP_FRONT, ACT_PEEK_BACK, ACT_PEEK_FRONT:
            begin
                if (is_empty)
                begin
                    cmd.status = ST_EMPTY;
                end
                else
                begin
                    cmd.op = OP_READ;
                    if (req.action == ACT_POP_BACK || req.action == ACT_PEEK_BACK)
                        cmd.addr = back_used_slot;
                    else
                        cmd.addr = front_reg;
                    if (req.action == ACT_POP_FRONT)
                        front_next = front_inc;
                    if (req.action == ACT_POP_BACK || req.action == ACT_POP_FRONT)
                        count_next = count_reg - CNT_W'(1);
                end
            end
            ACT_CLEAR:
            begin
                front_next = '0;
                count_next = '0;
            end
            default:
            begin
                front_next = front_reg;
            end
        endcase
        cmd.count = count_next;
    end

    // pointer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (xfer)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/deq_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_cmd_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module deq_cmd_fifo
    import deq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_cmd;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

endmodule

// ----- hw/rtl/deq_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_back
// Holds the entry memory, carries out writes and reads, and keeps the
// registered result until the receiver takes it.
// ----------------------------------------------------------------------------
module deq_back
    import deq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    deq_rsp_if.source   rsp
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic                  is_read_reg;
    logic [CNT_W-1:0]      count_reg;
    status_t               status_reg;
    logic                  valid_reg;
    logic                  take;

    assign cmd_ready = !valid_reg || rsp.ready;
    assign take      = cmd_valid && cmd_ready;

    // entry memory, at most one access per command
    always_ff @(posedge clk)
    begin
        if (take && cmd.op == OP_WRITE)
            mem[cmd.addr] <= cmd.data;
        if (take && cmd.op == OP_READ)
            rdata_reg <= mem[cmd.addr];
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            is_read_reg <= (cmd.op == OP_READ);
            count_reg   <= cmd.count;
            status_reg  <= cmd.status;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd_ready)
            valid_reg <= cmd_valid;
    end

    assign rsp.valid         = valid_reg;
    assign rsp.result_value  = is_read_reg ? VALUE_W'($unsigned(rdata_reg)) : '0;
    assign rsp.element_count = COUNT_W'(count_reg);
    assign rsp.status        = status_reg;

endmodule

// ----- hw/rtl/double_ended_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Ring-buffer double-ended queue with push, pop and peek at both ends.
// ----------------------------------------------------------------------------
// usage
//   req carries one request per transfer: action and value. rsp returns one
//   result per request, in order: result_value, element_count and status.
//   the front end updates the front pointer and count as each request is
//   taken and sends a storage command through a two-entry queue; the back
//   end does the memory write or read, if any, and registers the result.
//   each request is held in a command queue entry and then in the result
//   register of the back end. throughput: one request per cycle while rsp
//   does not stall, set by the single memory port of the back end, which
//   serves at most one access per command.
//   reset empties the queue (front pointer and count to zero) and drops any
//   pending results; the memory contents are not cleared.
//   when rsp stalls, the result register holds, the command queue fills and
//   req.ready falls once both queue entries are occupied.
// ----------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    deq_req_if.sink     req,
    deq_rsp_if.source   rsp
);

    logic cf_in_valid;
    logic cf_in_ready;
    cmd_t cf_in_cmd;
    logic cf_out_valid;
    logic cf_out_ready;
    cmd_t cf_out_cmd;

    // request classification
    deq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cf_in_valid),
        .cmd_ready (cf_in_ready),
        .cmd       (cf_in_cmd)
    );

    // decoupling queue
    deq_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cf_in_valid),
        .in_ready  (cf_in_ready),
        .in_cmd    (cf_in_cmd),
        .out_valid (cf_out_valid),
        .out_ready (cf_out_ready),
        .out_cmd   (cf_out_cmd)
    );

    // storage and result
    deq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cf_out_valid),
        .cmd_ready (cf_out_ready),
        .cmd       (cf_out_cmd),
        .rsp       (rsp)
    );

endmodule

// ----- tb/tb_double_ended_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the double-ended queue. Requests are driven in
// bursts with random gaps while the result side stalls in changing patterns.
// A scoreboard keeps its own ring of words, front slot and count. It works
// out the result of every accepted request and checks each returned result
// in order against it. A directed opening covers the empty queue, the
// unused selector, wrap of the front slot and clear. Random phases then fill
// the queue to full, drain it to empty and mix all requests in between.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
    import deq_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;

    // one predicted result
    typedef struct {
        logic [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } deq_result_t;

    // ring model of the queue and the results it still owes
    class deque_scoreboard;
        logic [DATA_WIDTH-1:0] words [DEPTH];
        int                    front_slot;
        int                    word_count;
        int                    errors;
        deq_result_t           owed_results [$];

        function new();
            front_slot = 0;
            word_count = 0;
            errors     = 0;
        endfunction

        // apply one accepted request and queue its result
        function void note_request(input logic [ACTION_W-1:0] act,
                                   input logic [VALUE_W-1:0] val);
            deq_result_t r;
            int          slot;
            r.value  = '0;
            r.status = ST_OK;
            case (act)
                ACT_PUSH_BACK, ACT_PUSH_FRONT:
                begin
                    if (word_count >= DEPTH)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        if (act == ACT_PUSH_BACK)
                        begin
                            slot = (front_slot + word_count) % DEPTH;
                        end
                        else
                        begin
                            front_slot = (front_slot + DEPTH - 1) % DEPTH;
                            slot = front_slot;
                        end
                        words[slot] = val[DATA_WIDTH-1:0];
                        word_count++;
                    end
                end
                ACT_POP_BACK, ACT_POP_FRONT, ACT_PEEK_BACK, ACT_PEEK_FRONT:
                begin
                    if (word_count == 0)
                    begin
                        r.status = ST_EMPTY;
                    end
                    else
                    begin
                        if (act == ACT_POP_BACK || act == ACT_PEEK_BACK)
                            slot = (front_slot + word_count - 1) % DEPTH;
                        else
                            slot = front_slot;
                        r.value = VALUE_W'(words[slot]);
                        if (act == ACT_POP_FRONT)
                            front_slot = (front_slot + 1) % DEPTH;
                        if (act == ACT_POP_BACK || act == ACT_POP_FRONT)
                            word_count--;
                    end
                end
                ACT_CLEAR:
                begin
                    word_count = 0;
                    front_slot = 0;
                end
                default:
                begin
                    // unused selector leaves everything alone
                end
            endcase
            r.count = COUNT_W'(word_count);
            owed_results.push_back(r);
        endfunction

        // compare one returned result with the oldest owed one
        function void check_result(input logic [VALUE_W-1:0] val,
                                   input logic [COUNT_W-1:0] cnt,
                                   input logic [STATUS_W-1:0] st);
            deq_result_t r;
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result value %h count %0d status %0d",
                         $time, val, cnt, st);
                errors++;
                return;
            end
            r = owed_results.pop_front();
            if (val !== r.value)
            begin
                $display("%0t: result_value expected %h actual %h", $time, r.value, val);
                errors++;
            end
            if (cnt !== r.count)
            begin
                $display("%0t: element_count expected %0d actual %0d", $time, r.count, cnt);
                errors++;
            end
            if (st !== r.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, r.status, st);
                errors++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    deq_req_if req_ch ();
    deq_rsp_if rsp_ch ();

    double_ended_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    deque_scoreboard sb;
    int cycle_count;
    int items_sent;
    int burst_left;
    int rx_mode;
    int rx_left;
    int rx_hold;
    bit rx_level;

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("double_ended_queue test failed");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.result_value, rsp_ch.element_count, rsp_ch.status);
    end

    // result side stall patterns, switched at random
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(40, 300);
            end
            else
            begin
                rx_left--;
            end
            case (rx_mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                2: rsp_ch.ready <= (rx_left % 5) >= 2;
                default:
                begin
                    // long low stretches with short high windows
                    if (rx_hold == 0)
                    begin
                        rx_level = !rx_level;
                        rx_hold  = rx_level ? $urandom_range(1, 4) : $urandom_range(5, 25);
                    end
                    else
                    begin
                        rx_hold--;
                    end
                    rsp_ch.ready <= rx_level;
                end
            endcase
        end
    end

    // random data word, extremes now and then
    function automatic logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // one request transfer, with a random gap at the end of each burst
    task automatic drive_item(input logic [ACTION_W-1:0] act,
                              input logic [VALUE_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.value  <= val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(act, val);
        items_sent++;
        @(negedge clk);
    endtask

    // push, with some peeks, until full, then a few refused pushes
    task automatic fill_phase();
        int r;
        int extra;
        while (sb.word_count < DEPTH)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                drive_item(ACT_PUSH_BACK, pick_word());
            else if (r < 8)
                drive_item(ACT_PUSH_FRONT, pick_word());
            else
                drive_item(r == 8 ? ACT_PEEK_BACK : ACT_PEEK_FRONT, pick_word());
        end
        extra = $urandom_range(1, 3);
        repeat (extra)
            drive_item($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, pick_word());
    endtask

    // pop, with some peeks, until empty, then a few empty pops and peeks
    task automatic drain_phase();
        int r;
        int extra;
        logic [ACTION_W-1:0] act;
        while (sb.word_count > 0)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                drive_item(ACT_POP_BACK, pick_word());
            else if (r < 8)
                drive_item(ACT_POP_FRONT, pick_word());
            else
                drive_item(r == 8 ? ACT_PEEK_BACK : ACT_PEEK_FRONT, pick_word());
        end
        extra = $urandom_range(1, 3);
        repeat (extra)
        begin
            case ($urandom_range(0, 3))
                0: act = ACT_POP_BACK;
                1: act = ACT_POP_FRONT;
                2: act = ACT_PEEK_BACK;
                default: act = ACT_PEEK_FRONT;
            endcase
            drive_item(act, pick_word());
        end
    endtask

    // any request, clear kept rare
    task automatic mixed_phase(input int len);
        logic [ACTION_W-1:0] act;
        repeat (len)
        begin
            act = ACTION_W'($urandom_range(0, 7));
            if (act == ACT_CLEAR && $urandom_range(0, 4) != 0)
                act = ACT_PUSH_BACK;
            drive_item(act, pick_word());
        end
    endtask

    initial
    begin
        int kind;
        sb          = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        cycle_count = 0;
        items_sent  = 0;
        burst_left  = 0;
        rx_mode     = 0;
        rx_left     = 0;
        rx_hold     = 0;
        rx_level    = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.action = '0;
        req_ch.value  = '0;
        rsp_ch.ready  = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty queue and unused selector
        drive_item(ACT_POP_BACK, 32'h1111_1111);
        drive_item(ACT_POP_FRONT, 32'h2222_2222);
        drive_item(ACT_PEEK_BACK, '1);
        drive_item(ACT_PEEK_FRONT, '0);
        drive_item(ACT_UNUSED, 32'hdead_beef);
        // front slot wraps below zero, extreme words at both ends
        drive_item(ACT_PUSH_FRONT, 32'h7fff_ffff);
        drive_item(ACT_PUSH_BACK, 32'h8000_0000);
        drive_item(ACT_PUSH_FRONT, '1);
        drive_item(ACT_PUSH_BACK, '0);
        drive_item(ACT_PEEK_FRONT, '0);
        drive_item(ACT_PEEK_BACK, '0);
        drive_item(ACT_UNUSED, '1);
        drive_item(ACT_POP_FRONT, '0);
        drive_item(ACT_POP_BACK, '0);
        drive_item(ACT_POP_FRONT, '0);
        drive_item(ACT_POP_BACK, '0);
        drive_item(ACT_POP_FRONT, '0);
        // clear with words stored
        drive_item(ACT_PUSH_BACK, 32'ha5a5_a5a5);
        drive_item(ACT_PUSH_BACK, 32'h5a5a_5a5a);
        drive_item(ACT_CLEAR, '1);
        drive_item(ACT_PEEK_BACK, '0);
        drive_item(ACT_PUSH_FRONT, 32'h1234_5678);
        drive_item(ACT_POP_BACK, '0);

        // random phases
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 3)
                fill_phase();
            else if (kind < 6)
                drain_phase();
            else
                mixed_phase($urandom_range(20, 80));
        end
        req_ch.valid <= 1'b0;

        // wait out the owed results, then the pipeline latency
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("double_ended_queue test passed");
        else
            $display("double_ended_queue test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/deq_pkg.sv
hw/rtl/deq_if.sv
hw/rtl/deq_front.sv
hw/rtl/deq_cmd_fifo.sv
hw/rtl/deq_back.sv
hw/rtl/double_ended_queue.sv
tb/tb_double_ended_queue.sv
